// File: design/ttb_pkg.sv
// Package for the triangle tangent and bitangent unit.
// It holds the shared constants and the command and status structs.
// It depends on nothing.
package ttb_pkg;

    // Fixed point scales.
    localparam int ONE_Q15   = 32768;
    localparam int FRAC_Q14  = 14;

    // Normalization window for the largest magnitude: [2^29, 2^30).
    localparam int NORM_LO_BIT = 29;
    localparam int NORM_HI_BIT = 30;

    // Iteration counts of the shared square root and divide units.
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    localparam int ITER_W     = $clog2(SQRT_STEPS);

    // Corner codes.
    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_LAST   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_c0;
        logic       load_c1;
        logic       load_tri;
        logic       det_mul;
        logic       tb_mul;
        logic       tb_fin;
        logic       dot_mul;
        logic       dot_sum;
        logic       proj_mul;
        logic       proj_fin;
        logic       norm_step;
        logic       sq_mul;
        logic       sq_sum;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic       store;
        logic       emit;
        logic       sel_b;
        logic [1:0] corner;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mx_zero;
        logic norm_ok;
        logic out_free;
    } t_status;

endpackage

// File: design/ttb_if.sv
// Request channel interfaces of the triangle tangent and bitangent unit.
// One interface carries corners in, the other carries per-corner results out.
// They depend on nothing.
interface ttb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, output ready);
endinterface

interface ttb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] bitan_x;
    logic signed [15:0] bitan_y;
    logic signed [15:0] bitan_z;
    logic        [1:0]  corner_index;
    logic               last_of_triangle;

    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    corner_index, last_of_triangle, input ready);
    modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    corner_index, last_of_triangle, output ready);
endinterface

// File: design/ttb_datapath.sv
// Datapath of the triangle tangent and bitangent unit: corner store,
// setup multipliers, projection, normalization, square root, dividers, output register.
// It depends on ttb_pkg and is driven by ttb_controller.
module ttb_datapath import ttb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [15:0] i_pos  [3],
    input  logic        [15:0] i_tex  [2],
    input  logic signed [15:0] i_norm [3],
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_tan   [3],
    output logic signed [15:0] o_bitan [3],
    output logic        [1:0]  o_corner_index,
    output logic               o_last
);

    // Held corners and the normal of the third corner.
    logic signed [15:0] r_c0_p [3];
    logic        [15:0] r_c0_uv [2];
    logic signed [15:0] r_c0_n [3];
    logic signed [15:0] r_c1_p [3];
    logic        [15:0] r_c1_uv [2];
    logic signed [15:0] r_c1_n [3];
    logic signed [15:0] r_n2 [3];

    // Triangle setup.
    logic signed [16:0] r_v [3];
    logic signed [16:0] r_w [3];
    logic signed [16:0] r_su, r_sv, r_tu, r_tv;
    logic signed [33:0] r_pa, r_pb;
    logic               r_neg;
    logic signed [33:0] r_wsv [3];
    logic signed [33:0] r_vtv [3];
    logic signed [33:0] r_wsu [3];
    logic signed [33:0] r_vtu [3];
    logic signed [35:0] r_t [3];
    logic signed [35:0] r_b [3];

    // Projection.
    logic signed [51:0] r_dp [3];
    logic signed [41:0] r_q;
    logic signed [57:0] r_pp [3];
    logic        [45:0] r_m [3];
    logic               r_mneg [3];
    logic        [45:0] r_mx;

    // Length and division.
    logic        [59:0] r_sq [3];
    logic        [61:0] r_rem;
    logic        [61:0] r_root;
    logic        [61:0] r_bit;
    logic        [30:0] r_drem [3];
    logic        [14:0] r_dlow [3];
    logic        [14:0] r_quo [3];

    // Results of the current corner and the output register.
    logic signed [15:0] r_tan [3];
    logic signed [15:0] r_btn [3];
    logic               r_ovalid;
    logic signed [15:0] r_o_tan [3];
    logic signed [15:0] r_o_btn [3];
    logic        [1:0]  r_o_corner;
    logic               r_o_last;

    // Combinational helpers.
    logic signed [35:0] vec [3];
    logic signed [15:0] nrm [3];
    logic               degen;
    logic signed [16:0] su_e, sv_e, tu_e, tv_e;
    logic signed [34:0] t_raw [3];
    logic signed [34:0] b_raw [3];
    logic signed [53:0] dsum;
    logic        [53:0] d_mag;
    logic        [53:0] d_rnd;
    logic        [40:0] q_mag;
    logic        [57:0] pp_mag [3];
    logic        [57:0] pp_rsum [3];
    logic signed [44:0] pp_rnd [3];
    logic signed [45:0] l_val [3];
    logic        [45:0] l_mag [3];
    logic        [45:0] l_max;
    logic        [61:0] sq_trial;
    logic        [30:0] root_r;
    logic        [44:0] num [3];
    logic        [31:0] rem2 [3];
    logic        [31:0] rem_sub [3];
    logic signed [15:0] q_signed [3];

    // Selection of the vector being worked on and of the corner normal.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec[i] = i_cmd.sel_b ? r_b[i] : r_t[i];
        end
        unique case (i_cmd.corner)
            CORNER_FIRST:  nrm = r_c0_n;
            CORNER_SECOND: nrm = r_c1_n;
            default:       nrm = r_n2;
        endcase
    end

    // Default UV axes when the UV area is zero.
    always_comb begin
        degen = (r_pa == r_pb);
        su_e  = degen ? 17'sd0 : r_su;
        sv_e  = degen ? 17'(ONE_Q15) : r_sv;
        tu_e  = degen ? 17'(ONE_Q15) : r_tu;
        tv_e  = degen ? 17'sd0 : r_tv;
        for (int i = 0; i < 3; i++) begin
            t_raw[i] = 35'(r_wsv[i]) - 35'(r_vtv[i]);
            b_raw[i] = 35'(r_wsu[i]) - 35'(r_vtu[i]);
        end
    end

    // Dot product and its rounding to Q1.14 scale (half away from zero).
    always_comb begin
        dsum  = 54'(r_dp[0]) + 54'(r_dp[1]) + 54'(r_dp[2]);
        d_mag = dsum[53] ? 54'(-dsum) : 54'(dsum);
        d_rnd = d_mag + 54'd8192;
        q_mag = 41'(d_rnd[53:14]);
    end

    // Projection: subtract the rounded normal component, then take magnitudes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pp_mag[i]  = r_pp[i][57] ? 58'(-r_pp[i]) : 58'(r_pp[i]);
            pp_rsum[i] = pp_mag[i] + 58'd8192;
            pp_rnd[i]  = r_pp[i][57] ? -$signed({1'b0, pp_rsum[i][57:14]})
                                     : $signed({1'b0, pp_rsum[i][57:14]});
            l_val[i]   = 46'(vec[i]) - 46'(pp_rnd[i]);
            l_mag[i]   = l_val[i][45] ? 46'(-l_val[i]) : 46'(l_val[i]);
        end
        l_max = l_mag[0];
        if (l_mag[1] > l_max) begin
            l_max = l_mag[1];
        end
        if (l_mag[2] > l_max) begin
            l_max = l_mag[2];
        end
    end

    // Square root trial and the divider steps.
    always_comb begin
        sq_trial = r_root + r_bit;
        root_r   = r_root[30:0];
        for (int i = 0; i < 3; i++) begin
            num[i]      = {1'b0, r_m[i][29:0], 14'd0} + 45'(root_r >> 1);
            rem2[i]     = {r_drem[i], r_dlow[i][14]};
            rem_sub[i]  = rem2[i] - {1'b0, root_r};
            q_signed[i] = r_mneg[i] ? -$signed({1'b0, r_quo[i]})
                                    : $signed({1'b0, r_quo[i]});
        end
    end

    // Corner store and triangle setup registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c0) begin
            r_c0_p  <= i_pos;
            r_c0_uv <= i_tex;
            r_c0_n  <= i_norm;
        end
        if (i_cmd.load_c1) begin
            r_c1_p  <= i_pos;
            r_c1_uv <= i_tex;
            r_c1_n  <= i_norm;
        end
        if (i_cmd.load_tri) begin
            r_n2 <= i_norm;
            for (int i = 0; i < 3; i++) begin
                r_v[i] <= 17'(r_c1_p[i]) - 17'(r_c0_p[i]);
                r_w[i] <= 17'(i_pos[i]) - 17'(r_c0_p[i]);
            end
            r_su <= $signed({1'b0, r_c1_uv[0]}) - $signed({1'b0, r_c0_uv[0]});
            r_sv <= $signed({1'b0, r_c1_uv[1]}) - $signed({1'b0, r_c0_uv[1]});
            r_tu <= $signed({1'b0, i_tex[0]}) - $signed({1'b0, r_c0_uv[0]});
            r_tv <= $signed({1'b0, i_tex[1]}) - $signed({1'b0, r_c0_uv[1]});
        end
        if (i_cmd.det_mul) begin
            r_pa <= r_su * r_tv;
            r_pb <= r_sv * r_tu;
        end
        if (i_cmd.tb_mul) begin
            r_neg <= (r_pb < r_pa);
            for (int i = 0; i < 3; i++) begin
                r_wsv[i] <= r_w[i] * sv_e;
                r_vtv[i] <= r_v[i] * tv_e;
                r_wsu[i] <= r_w[i] * su_e;
                r_vtu[i] <= r_v[i] * tu_e;
            end
        end
        if (i_cmd.tb_fin) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= r_neg ? -36'(t_raw[i]) : 36'(t_raw[i]);
                r_b[i] <= r_neg ? -36'(b_raw[i]) : 36'(b_raw[i]);
            end
        end
    end

    // Projection and normalization registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.dot_mul) begin
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= vec[i] * nrm[i];
            end
        end
        if (i_cmd.dot_sum) begin
            r_q <= dsum[53] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        end
        if (i_cmd.proj_mul) begin
            for (int i = 0; i < 3; i++) begin
                r_pp[i] <= nrm[i] * r_q;
            end
        end
        if (i_cmd.proj_fin) begin
            r_m    <= l_mag;
            r_mx   <= l_max;
            for (int i = 0; i < 3; i++) begin
                r_mneg[i] <= l_val[i][45];
            end
        end else if (i_cmd.norm_step) begin
            // Right shifts truncate; left shifts are exact.
            if (r_mx >= (46'd1 << NORM_HI_BIT)) begin
                r_mx <= r_mx >> 1;
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_m[i] >> 1;
                end
            end else begin
                r_mx <= r_mx << 1;
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_m[i] << 1;
                end
            end
        end
    end

    // Squares, square root digit recurrence and the three dividers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m[i][29:0] * r_m[i][29:0];
            end
        end
        if (i_cmd.sq_sum) begin
            r_rem  <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
            r_root <= '0;
            r_bit  <= 62'd1 << (2 * (SQRT_STEPS - 1));
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= sq_trial) begin
                r_rem  <= r_rem - sq_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_load) begin
            for (int i = 0; i < 3; i++) begin
                r_drem[i] <= {1'b0, num[i][44:15]};
                r_dlow[i] <= num[i][14:0];
                r_quo[i]  <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                if (rem2[i] >= {1'b0, root_r}) begin
                    r_drem[i] <= rem_sub[i][30:0];
                    r_quo[i]  <= {r_quo[i][13:0], 1'b1};
                end else begin
                    r_drem[i] <= rem2[i][30:0];
                    r_quo[i]  <= {r_quo[i][13:0], 1'b0};
                end
                r_dlow[i] <= r_dlow[i] << 1;
            end
        end
        if (i_cmd.store) begin
            for (int i = 0; i < 3; i++) begin
                if (i_cmd.sel_b) begin
                    r_btn[i] <= (r_mx == '0) ? 16'sd0 : q_signed[i];
                end else begin
                    r_tan[i] <= (r_mx == '0) ? 16'sd0 : q_signed[i];
                end
            end
        end
    end

    // Output register: a result waits here while the next corner is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_tan    <= r_tan;
            r_o_btn    <= r_btn;
            r_o_corner <= i_cmd.corner;
            r_o_last   <= (i_cmd.corner == CORNER_LAST);
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_tan             = r_o_tan;
    assign o_bitan           = r_o_btn;
    assign o_corner_index    = r_o_corner;
    assign o_last            = r_o_last;
    assign o_status.mx_zero  = (r_mx == '0);
    assign o_status.norm_ok  = (r_mx[45:NORM_HI_BIT] == '0) && r_mx[NORM_LO_BIT];
    assign o_status.out_free = !r_ovalid || i_out_ready;

    // The squares are taken only of a normalized vector.
    a_sq_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_mul |-> (r_mx[45:NORM_HI_BIT] == '0) && r_mx[NORM_LO_BIT])
        else $error("squares taken of a vector outside the normalization window");

    // The length is never below the largest component, so quotients stay in Q1.14.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> (r_root >= 62'(r_mx)) && (r_root[61:31] == '0))
        else $error("vector length out of range at divide start");

    // A pending result is never overwritten.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_out_ready))
        else $error("result emitted while the output register is full");

endmodule

// File: design/ttb_controller.sv
// Controller of the triangle tangent and bitangent unit: corner counting and
// the sequence of datapath steps for six projected vectors per triangle.
// It depends on ttb_pkg and drives ttb_datapath.
module ttb_controller import ttb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DETM, S_TBM, S_TBF, S_DOT, S_DSUM, S_PMUL, S_PFIN,
        S_NORM, S_SQ, S_SUM, S_SQRT, S_DIVLD, S_DIV, S_STORE, S_EMIT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_cnt;
    logic [1:0]          r_k;
    logic                r_sel;
    logic [ITER_W-1:0]   r_iter;
    logic                accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // Commands follow the state; corner loads follow the corner count.
    always_comb begin
        o_cmd           = '0;
        o_cmd.sel_b     = r_sel;
        o_cmd.corner    = r_k;
        o_cmd.load_c0   = accept && (r_cnt == CORNER_FIRST);
        o_cmd.load_c1   = accept && (r_cnt == CORNER_SECOND);
        o_cmd.load_tri  = accept && (r_cnt == CORNER_LAST);
        o_cmd.det_mul   = (r_state == S_DETM);
        o_cmd.tb_mul    = (r_state == S_TBM);
        o_cmd.tb_fin    = (r_state == S_TBF);
        o_cmd.dot_mul   = (r_state == S_DOT);
        o_cmd.dot_sum   = (r_state == S_DSUM);
        o_cmd.proj_mul  = (r_state == S_PMUL);
        o_cmd.proj_fin  = (r_state == S_PFIN);
        o_cmd.norm_step = (r_state == S_NORM) && !i_status.mx_zero && !i_status.norm_ok;
        o_cmd.sq_mul    = (r_state == S_SQ);
        o_cmd.sq_sum    = (r_state == S_SUM);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.div_load  = (r_state == S_DIVLD);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.store     = (r_state == S_STORE);
        o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;
    end

    // State, corner count, corner and vector select, iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= CORNER_FIRST;
            r_k     <= CORNER_FIRST;
            r_sel   <= 1'b0;
            r_iter  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_cnt == CORNER_LAST) begin
                            r_cnt   <= CORNER_FIRST;
                            r_k     <= CORNER_FIRST;
                            r_sel   <= 1'b0;
                            r_state <= S_DETM;
                        end else begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
                S_DETM:  r_state <= S_TBM;
                S_TBM:   r_state <= S_TBF;
                S_TBF:   r_state <= S_DOT;
                S_DOT:   r_state <= S_DSUM;
                S_DSUM:  r_state <= S_PMUL;
                S_PMUL:  r_state <= S_PFIN;
                S_PFIN:  r_state <= S_NORM;
                S_NORM: begin
                    // A zero vector skips straight to a zero result.
                    if (i_status.mx_zero) begin
                        r_state <= S_STORE;
                    end else if (i_status.norm_ok) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ:    r_state <= S_SUM;
                S_SUM: begin
                    r_iter  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_iter == ITER_W'(SQRT_STEPS - 1)) begin
                        r_state <= S_DIVLD;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_DIVLD: begin
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                        r_state <= S_STORE;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_STORE: begin
                    if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= S_DOT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_sel <= 1'b0;
                        if (r_k == CORNER_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DOT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The third corner always starts the triangle sequence.
    a_tri_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_tri |=> (r_state == S_DETM) && (r_cnt == CORNER_FIRST))
        else $error("third corner did not start the triangle sequence");

endmodule

// File: design/triangle_tangent_bitangent.sv
// Top level of the triangle tangent and bitangent unit.
// It depends on ttb_pkg, ttb_if, ttb_controller and ttb_datapath.
//
// Usage:
//   Corners enter on i_in, one request per corner, accepted when valid and
//   ready are both high. The first and second corner of a triangle are held.
//   The third corner starts the triangle work and ready stays low until all
//   three results have been handed to the output register.
//   Results leave on o_out, one request per corner in corner order, the third
//   one marked last_of_triangle.
//   Sequence: the triangle setup comes first, then each of the six projected
//   vectors runs through the projection, the normalizing shifts, the shared
//   31-step square root and the 15-step dividers; a zero vector skips the
//   root and the dividers. Each result is then handed to the output register.
//   The output register holds one result; while it is full the next corner is
//   still computed, and the sequence waits only when a new result is ready.
//   Reset clears the corner count and the output valid; a triangle in work is
//   dropped.
module triangle_tangent_bitangent import ttb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ttb_in_if.sink         i_in,
    ttb_out_if.source      o_out
);

    t_cmd               cmd;
    t_status            status;
    logic signed [15:0] in_pos  [3];
    logic        [15:0] in_tex  [2];
    logic signed [15:0] in_norm [3];
    logic signed [15:0] out_tan   [3];
    logic signed [15:0] out_bitan [3];

    // Gather the corner fields into vectors.
    assign in_pos[0]  = i_in.pos_x;
    assign in_pos[1]  = i_in.pos_y;
    assign in_pos[2]  = i_in.pos_z;
    assign in_tex[0]  = i_in.tex_u;
    assign in_tex[1]  = i_in.tex_v;
    assign in_norm[0] = i_in.norm_x;
    assign in_norm[1] = i_in.norm_y;
    assign in_norm[2] = i_in.norm_z;

    ttb_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ttb_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_pos          (in_pos),
        .i_tex          (in_tex),
        .i_norm         (in_norm),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_tan          (out_tan),
        .o_bitan        (out_bitan),
        .o_corner_index (o_out.corner_index),
        .o_last         (o_out.last_of_triangle)
    );

    // Spread the result vectors onto the output fields.
    assign o_out.tan_x   = out_tan[0];
    assign o_out.tan_y   = out_tan[1];
    assign o_out.tan_z   = out_tan[2];
    assign o_out.bitan_x = out_bitan[0];
    assign o_out.bitan_y = out_bitan[1];
    assign o_out.bitan_z = out_bitan[2];

endmodule
